// ===== hw/rtl/epve_pkg.sv =====
package epve_pkg;

  localparam int STEP_W  = 48;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = STEP_W;
  localparam int IDX_W   = 1;
  localparam int DIV_STEPS = STEP_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  localparam logic [IDX_W-1:0] REG_SCALED_STEP = 1'b0;
  localparam logic [IDX_W-1:0] REG_SPEED_LIMIT = 1'b1;

  localparam logic [STEP_W-1:0] SCALED_STEP_RESET = 48'd3457876312;
  localparam logic [DATA_W-1:0] SPEED_LIMIT_RESET = 32'd4915200;

  localparam logic [DATA_W-1:0] VEL_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VEL_NEG_MAG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } epve_cmd_t;

  typedef struct packed {
    logic div_last;
  } epve_status_t;

endpackage

// ===== hw/rtl/epve_ctrl.sv =====
module epve_ctrl
  import epve_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  epve_status_t status,
  output epve_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/epve_datapath.sv =====
module epve_datapath
  import epve_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [DATA_W-1:0]        edge_time_us,
  input  logic                     channel_b,
  input  epve_cmd_t                cmd,
  output epve_status_t             status,
  output logic signed [DATA_W-1:0] position_count,
  output logic signed [DATA_W-1:0] velocity,
  output logic                     rejected
);

  logic [STEP_W-1:0]     scaled_step;
  logic [DATA_W-1:0]     speed_limit;
  logic [DATA_W-1:0]     count;
  logic [DATA_W-1:0]     last_edge_time;
  logic [DATA_W-1:0]     accepted_velocity;

  logic [STEP_W-1:0]     quo;
  logic [DATA_W-1:0]     rem;
  logic [DATA_W-1:0]     divisor;
  logic                  forward;
  logic                  interval_zero;
  logic [STEP_CNT_W-1:0] step_cnt;

  logic [DATA_W-1:0]     interval;
  logic [DATA_W+1:0]     trial;
  logic [DATA_W:0]       partial;
  logic                  reject_now;
  logic [DATA_W-1:0]     new_vel;
  logic [DATA_W-1:0]     vel_out;

  assign interval = edge_time_us - last_edge_time;
  assign status.div_last = (step_cnt == STEP_CNT_W'(DIV_STEPS - 1));

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign partial = {rem, quo[STEP_W-1]};
  assign trial   = {1'b0, partial} - {2'b00, divisor};

  assign reject_now = interval_zero || (quo > {{(STEP_W-DATA_W){1'b0}}, speed_limit});

  always_comb begin
    if (forward) begin
      new_vel = quo[DATA_W-1] ? VEL_POS_MAX : quo[DATA_W-1:0];
    end else if (quo[DATA_W-1:0] > VEL_NEG_MAG_MAX) begin
      new_vel = VEL_NEG_MAG_MAX;
    end else begin
      new_vel = DATA_W'(0) - quo[DATA_W-1:0];
    end
    vel_out = reject_now ? accepted_velocity : new_vel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_step       <= SCALED_STEP_RESET;
      speed_limit       <= SPEED_LIMIT_RESET;
      count             <= '0;
      last_edge_time    <= '0;
      accepted_velocity <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCALED_STEP: scaled_step <= cfg_data;
          REG_SPEED_LIMIT: speed_limit <= cfg_data[DATA_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        count          <= channel_b ? count + DATA_W'(1) : count - DATA_W'(1);
        last_edge_time <= edge_time_us;
      end
      if (cmd.finish && !reject_now) begin
        accepted_velocity <= new_vel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo           <= scaled_step;
      rem           <= '0;
      divisor       <= interval;
      forward       <= channel_b;
      interval_zero <= (interval == '0);
      step_cnt      <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + STEP_CNT_W'(1);
      if (!trial[DATA_W+1]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[STEP_W-2:0], 1'b1};
      end else begin
        rem <= partial[DATA_W-1:0];
        quo <= {quo[STEP_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      position_count <= count;
      velocity       <= vel_out;
      rejected       <= reject_now;
    end
  end

endmodule

// ===== hw/rtl/encoder_period_velocity_estimator.sv =====
// encoder velocity from edge period: each input word is one rising edge of
// channel a with its microsecond timestamp and the channel b level. b high
// counts the position up, b low counts it down. velocity is scaled_step
// divided by the time since the previous edge, signed q16.16 mm/s; a zero
// interval or a magnitude above speed_limit repeats the last accepted
// velocity and raises rejected. one result word per edge. an edge goes
// through the load, the bit-serial restoring divider (48-bit step by
// 32-bit interval, one quotient bit a cycle) and the forming and
// registering of the result before the next edge can be taken. the
// finished result waits in the output register, so a new edge is
// accepted while it is still stalled; the result is only held up if the
// previous one is still not taken when the next division ends. config
// writes (index 0 scaled_step, index 1 speed_limit) belong in idle time
// only.
module encoder_period_velocity_estimator
  import epve_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DATA_W-1:0]        edge_time_us,
  input  logic                     channel_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] position_count,
  output logic signed [DATA_W-1:0] velocity,
  output logic                     rejected
);

  // commands from the controller, divider status back
  epve_cmd_t    cmd;
  epve_status_t status;

  // sequencer: idle, divide, finish
  epve_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // registers, position count, divider and result register
  epve_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .edge_time_us   (edge_time_us),
    .channel_b      (channel_b),
    .cmd            (cmd),
    .status         (status),
    .position_count (position_count),
    .velocity       (velocity),
    .rejected       (rejected)
  );

endmodule
